// ----- sv/lfst_pkg.sv -----
// ----------------------------------------------------------------------------
// lfst_pkg
// Shared field widths, action and status codes, and the command and status
// groups that pass between the slot table controller and its datapath.
// ----------------------------------------------------------------------------
package lfst_pkg;

  localparam int ACT_FW    = 3;
  localparam int HANDLE_FW = 32;
  localparam int SLOT_FW   = 4;
  localparam int SIG_FW    = 4;
  localparam int MASK_FW   = 16;
  localparam int STATUS_FW = 2;

  localparam logic [ACT_FW-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACT_FW-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACT_FW-1:0] ACT_LOOKUP  = 3'd2;
  localparam logic [ACT_FW-1:0] ACT_BLOCK   = 3'd3;
  localparam logic [ACT_FW-1:0] ACT_UNBLOCK = 3'd4;

  localparam logic [STATUS_FW-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_FW-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_FW-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic look;
    logic scan;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic [ACT_FW-1:0] act;
    logic              full;
    logic              slot_ok;
    logic              sig_ok;
    logic              scan_done;
    logic              sweep_last;
  } stat_t;

endpackage

// ----- sv/lfst_ram.sv -----
// ----------------------------------------------------------------------------
// lfst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lfst_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfst_ctrl
// Sequencer for the slot table: takes a command, runs the execute beat,
// then the lookup read, the free-slot scan or the signal sweep as needed.
// ----------------------------------------------------------------------------
module lfst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lfst_pkg::stat_t stat,
  output lfst_pkg::cmd_t  cmd
);
  import lfst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_SWEEP = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.act)
          ACT_INSERT:  state_next = stat.full ? S_IDLE : S_SCAN;
          ACT_LOOKUP:  state_next = stat.slot_ok ? S_LOOK : S_IDLE;
          ACT_BLOCK,
          ACT_UNBLOCK: state_next = stat.sig_ok ? S_SWEEP : S_IDLE;
          default:     state_next = S_IDLE;
        endcase
      end
      S_LOOK:  state_next = S_IDLE;
      S_SCAN: begin
        if (stat.scan_done) state_next = S_IDLE;
      end
      S_SWEEP: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign cmd.load  = (state == S_IDLE) && start;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.look  = (state == S_LOOK);
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.sweep = (state == S_SWEEP);

endmodule

// ----- sv/lfst_dp.sv -----
// ----------------------------------------------------------------------------
// lfst_dp
// Slot table datapath: occupancy bits, first-free pointer, handle and mask
// RAMs, the scan and sweep pointer, and the result registers.
// ----------------------------------------------------------------------------
module lfst_dp #(
  parameter int CAPACITY    = 16,
  parameter int NUM_SIGNALS = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lfst_pkg::cmd_t                   cmd,
  output lfst_pkg::stat_t                  stat,
  input  logic [lfst_pkg::ACT_FW-1:0]      action,
  input  logic [lfst_pkg::HANDLE_FW-1:0]   handle_in,
  input  logic [lfst_pkg::SLOT_FW-1:0]     slot_in,
  input  logic [lfst_pkg::SIG_FW-1:0]      signal_in,
  output logic                             done,
  output logic [lfst_pkg::SLOT_FW-1:0]     slot_out,
  output logic [lfst_pkg::HANDLE_FW-1:0]   handle_out,
  output logic [lfst_pkg::MASK_FW-1:0]     mask_out,
  output logic [lfst_pkg::STATUS_FW-1:0]   status
);
  import lfst_pkg::*;

  localparam int SlotW = $clog2(CAPACITY);
  localparam int PtrW  = SlotW + 1;
  localparam int CmpW  = (PtrW > SLOT_FW) ? PtrW : SLOT_FW;
  localparam int HandW = (HANDLE_BITS > HANDLE_FW) ? HANDLE_BITS : HANDLE_FW;
  localparam int MaskW = (NUM_SIGNALS > MASK_FW) ? NUM_SIGNALS : MASK_FW;
  localparam int SigCmpW = 7;

  logic [ACT_FW-1:0]    act_r;
  logic [HANDLE_FW-1:0] handle_r;
  logic [SLOT_FW-1:0]   slot_r;
  logic [SIG_FW-1:0]    sig_r;

  logic [CAPACITY-1:0]  occupied;
  logic [PtrW-1:0]      first_free;
  logic [PtrW-1:0]      ptr;
  logic [PtrW-1:0]      ptr_inc;

  logic [CmpW-1:0]      slot_ext;
  logic [CmpW-1:0]      ff_ext;
  logic [SlotW-1:0]     slot_idx;
  logic [SlotW-1:0]     ff_idx;
  logic [SlotW-1:0]     ptr_idx;
  logic                 slot_in_range;
  logic                 ptr_in_range;
  logic                 occ_at_ptr;

  logic [HandW-1:0]       hin_ext;
  logic [HandW-1:0]       hout_ext;
  logic [HANDLE_BITS-1:0] h_rdata;
  logic                   h_we;

  logic [MaskW-1:0]       mout_ext;
  logic [NUM_SIGNALS-1:0] m_rdata;
  logic [NUM_SIGNALS-1:0] m_wdata;
  logic [NUM_SIGNALS-1:0] m_mod;
  logic [NUM_SIGNALS-1:0] sig_bit;
  logic [SlotW-1:0]       m_waddr;
  logic [SlotW-1:0]       m_raddr;
  logic                   m_we;
  logic                   ins_ok;

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= action;
      handle_r <= handle_in;
      slot_r   <= slot_in;
      sig_r    <= signal_in;
    end
  end

  assign slot_ext      = CmpW'(slot_r);
  assign ff_ext        = CmpW'(first_free);
  assign slot_idx      = slot_ext[SlotW-1:0];
  assign ff_idx        = first_free[SlotW-1:0];
  assign ptr_idx       = ptr[SlotW-1:0];
  assign ptr_inc       = ptr + 1'b1;
  assign slot_in_range = slot_ext < CmpW'(CAPACITY);
  assign ptr_in_range  = ptr < PtrW'(CAPACITY);
  assign occ_at_ptr    = ptr_in_range ? occupied[ptr_idx] : 1'b0;

  assign stat.act        = act_r;
  assign stat.full       = (first_free == PtrW'(CAPACITY));
  assign stat.slot_ok    = slot_in_range ? occupied[slot_idx] : 1'b0;
  assign stat.sig_ok     = SigCmpW'(sig_r) < SigCmpW'(NUM_SIGNALS);
  assign stat.scan_done  = !occ_at_ptr;
  assign stat.sweep_last = (ptr == PtrW'(CAPACITY - 1));

  assign ins_ok = cmd.exec && (act_r == ACT_INSERT) && !stat.full;

  // occupancy, first-free pointer, scan and sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied   <= '0;
      first_free <= '0;
    end else begin
      if (ins_ok) begin
        occupied[ff_idx] <= 1'b1;
      end
      if (cmd.exec && (act_r == ACT_REMOVE) && stat.slot_ok) begin
        occupied[slot_idx] <= 1'b0;
        if ({1'b0, slot_idx} < first_free) first_free <= {1'b0, slot_idx};
      end
      if (cmd.scan && stat.scan_done) begin
        first_free <= ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ptr <= (act_r == ACT_INSERT) ? first_free + 1'b1 : '0;
    end else if (cmd.scan || cmd.sweep) begin
      ptr <= ptr_inc;
    end
  end

  // handle store
  assign hin_ext = HandW'(handle_r);
  assign h_we    = ins_ok;

  lfst_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (CAPACITY)
  ) u_handle_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (ff_idx),
    .wdata (hin_ext[HANDLE_BITS-1:0]),
    .raddr (slot_idx),
    .rdata (h_rdata)
  );

  // blocked-signal mask store, read-modify-write during the sweep
  assign sig_bit = NUM_SIGNALS'(1) << sig_r;
  assign m_mod   = (act_r == ACT_BLOCK) ? (m_rdata | sig_bit) : (m_rdata & ~sig_bit);
  assign m_we    = ins_ok || (cmd.sweep && occ_at_ptr);
  assign m_waddr = cmd.sweep ? ptr_idx : ff_idx;
  assign m_wdata = cmd.sweep ? m_mod : '0;
  assign m_raddr = cmd.sweep ? ptr_inc[SlotW-1:0] :
                   ((act_r == ACT_LOOKUP) ? slot_idx : '0);

  lfst_ram #(
    .WIDTH (NUM_SIGNALS),
    .DEPTH (CAPACITY)
  ) u_mask_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  assign hout_ext = HandW'(h_rdata);
  assign mout_ext = MaskW'(m_rdata);

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.exec && !((act_r == ACT_LOOKUP) && stat.slot_ok)) || cmd.look;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      slot_out   <= slot_r;
      handle_out <= '0;
      mask_out   <= '0;
      status     <= ST_OK;
      unique case (act_r)
        ACT_INSERT: begin
          if (stat.full) begin
            slot_out <= '0;
            status   <= ST_FULL;
          end else begin
            slot_out <= ff_ext[SLOT_FW-1:0];
          end
        end
        ACT_REMOVE,
        ACT_LOOKUP: begin
          if (!stat.slot_ok) status <= ST_EMPTY;
        end
        default: begin
        end
      endcase
    end else if (cmd.look) begin
      slot_out   <= slot_r;
      handle_out <= hout_ext[HANDLE_FW-1:0];
      mask_out   <= mout_ext[MASK_FW-1:0];
      status     <= ST_OK;
    end
  end

endmodule

// ----- sv/lowest_free_slot_table.sv -----
// ----------------------------------------------------------------------------
// lowest_free_slot_table
// Fixed-capacity task handle table with lowest-free-first slot ids.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high, and must be
// taken then. Remove, a full insert, an empty-slot lookup, an out-of-range
// signal and unknown actions run only the execute beat before the next
// command can be taken; a good lookup adds a lookup beat (registered handle
// and mask RAM read). A good insert gives its result after the execute beat
// but stays busy while the first-free scan visits the following slots, one
// slot a cycle. Block and unblock walk the whole mask RAM one entry a cycle.
module lowest_free_slot_table #(
  parameter int CAPACITY    = 16,
  parameter int NUM_SIGNALS = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [lfst_pkg::ACT_FW-1:0]      action,
  input  logic [lfst_pkg::HANDLE_FW-1:0]   handle_in,
  input  logic [lfst_pkg::SLOT_FW-1:0]     slot_in,
  input  logic [lfst_pkg::SIG_FW-1:0]      signal_in,
  output logic                             done,
  output logic [lfst_pkg::SLOT_FW-1:0]     slot_out,
  output logic [lfst_pkg::HANDLE_FW-1:0]   handle_out,
  output logic [lfst_pkg::MASK_FW-1:0]     mask_out,
  output logic [lfst_pkg::STATUS_FW-1:0]   status
);
  import lfst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lfst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lfst_dp #(
    .CAPACITY    (CAPACITY),
    .NUM_SIGNALS (NUM_SIGNALS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (action),
    .handle_in  (handle_in),
    .slot_in    (slot_in),
    .signal_in  (signal_in),
    .done       (done),
    .slot_out   (slot_out),
    .handle_out (handle_out),
    .mask_out   (mask_out),
    .status     (status)
  );

endmodule

// ----- sv/lfst_checker.sv -----
// ----------------------------------------------------------------------------
// lfst_checker
// Port-level checks for the slot table, bound to the top level.
// ----------------------------------------------------------------------------
module lfst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [lfst_pkg::SLOT_FW-1:0]     slot_out,
  input logic [lfst_pkg::HANDLE_FW-1:0]   handle_out,
  input logic [lfst_pkg::MASK_FW-1:0]     mask_out,
  input logic [lfst_pkg::STATUS_FW-1:0]   status
);
  import lfst_pkg::*;

  // a result beat only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in flight");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result beats");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (slot_out == '0 && handle_out == '0 && mask_out == '0))
    else $error("table-full result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
    else $error("undefined status code");

endmodule

bind lowest_free_slot_table lfst_checker u_chk (.*);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lowest_free_slot_table. Commands go in over the
// start/busy handshake with random sender gaps. Each command is run through
// a local copy of the table at the edge it is taken. Every done beat is
// compared field by field against the oldest pending reply. Directed edge
// cases come first: unknown actions, empty and full table, zero and all-ones
// handles, low and high signals. Then come random bursts that swing the
// table between nearly empty and full.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfst_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int NUM_SIGNALS   = 16;
  localparam int HANDLE_BITS   = 32;
  localparam int SETTLE_CYCLES = CAPACITY + 4;
  localparam logic [ACT_FW-1:0] ACT_UNKNOWN_HI = '1;

  typedef struct packed {
    logic [SLOT_FW-1:0]   slot;
    logic [HANDLE_FW-1:0] handle;
    logic [MASK_FW-1:0]   mask;
    logic [STATUS_FW-1:0] status;
  } slot_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ACT_FW-1:0]    action = ACT_INSERT;
  logic [HANDLE_FW-1:0] handle_in = '0;
  logic [SLOT_FW-1:0]   slot_in = '0;
  logic [SIG_FW-1:0]    signal_in = '0;
  logic                 done;
  logic [SLOT_FW-1:0]   slot_out;
  logic [HANDLE_FW-1:0] handle_out;
  logic [MASK_FW-1:0]   mask_out;
  logic [STATUS_FW-1:0] status;

  bit                   slot_used [CAPACITY];
  logic [HANDLE_FW-1:0] slot_handle [CAPACITY];
  logic [MASK_FW-1:0]   slot_mask [CAPACITY];
  int                   lowest_free = 0;
  slot_reply_t          pending_replies [$];
  int                   errors = 0;
  int                   sender_idle_pct = 0;

  lowest_free_slot_table #(
    .CAPACITY    (CAPACITY),
    .NUM_SIGNALS (NUM_SIGNALS),
    .HANDLE_BITS (HANDLE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .handle_in  (handle_in),
    .slot_in    (slot_in),
    .signal_in  (signal_in),
    .done       (done),
    .slot_out   (slot_out),
    .handle_out (handle_out),
    .mask_out   (mask_out),
    .status     (status)
  );

  always #10 clk = ~clk;

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic slot_reply_t apply_table_op(input logic [ACT_FW-1:0] act,
                                                 input logic [HANDLE_FW-1:0] hnd,
                                                 input logic [SLOT_FW-1:0] slt,
                                                 input logic [SIG_FW-1:0] sg);
    slot_reply_t r;
    int          id;
    bit          hit;
    r.slot   = slt;
    r.handle = '0;
    r.mask   = '0;
    r.status = ST_OK;
    hit      = (int'(slt) < CAPACITY) && slot_used[slt];
    case (act)
      ACT_INSERT: begin
        if (lowest_free >= CAPACITY) begin
          r.slot   = '0;
          r.status = ST_FULL;
        end else begin
          id              = lowest_free;
          slot_used[id]   = 1'b1;
          slot_handle[id] = hnd;
          slot_mask[id]   = '0;
          r.slot          = id[SLOT_FW-1:0];
          id++;
          while (id < CAPACITY && slot_used[id]) id++;
          lowest_free = id;
        end
      end
      ACT_REMOVE: begin
        if (!hit) begin
          r.status = ST_EMPTY;
        end else begin
          slot_used[slt] = 1'b0;
          if (int'(slt) < lowest_free) lowest_free = int'(slt);
        end
      end
      ACT_LOOKUP: begin
        if (!hit) begin
          r.status = ST_EMPTY;
        end else begin
          r.handle = slot_handle[slt];
          r.mask   = slot_mask[slt];
        end
      end
      ACT_BLOCK, ACT_UNBLOCK: begin
        if (int'(sg) < NUM_SIGNALS) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i]) slot_mask[i][sg] = (act == ACT_BLOCK);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_cmd(input logic [ACT_FW-1:0] act,
                          input logic [HANDLE_FW-1:0] hnd,
                          input logic [SLOT_FW-1:0] slt,
                          input logic [SIG_FW-1:0] sg);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    action    <= act;
    handle_in <= hnd;
    slot_in   <= slt;
    signal_in <= sg;
    do @(posedge clk); while (busy !== 1'b0);
    pending_replies.push_back(apply_table_op(act, hnd, slt, sg));
  endtask

  task automatic check_field(input string name, input logic [HANDLE_FW-1:0] exp_v,
                             input logic [HANDLE_FW-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : reply_check
    slot_reply_t exp_r;
    if (!rst && done === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected beat, slot %0h handle %0h mask %0h status %0h",
                 $time, slot_out, handle_out, mask_out, status);
        errors++;
      end else begin
        exp_r = pending_replies.pop_front();
        check_field("slot_out", HANDLE_FW'(exp_r.slot), HANDLE_FW'(slot_out));
        check_field("handle_out", exp_r.handle, handle_out);
        check_field("mask_out", HANDLE_FW'(exp_r.mask), HANDLE_FW'(mask_out));
        check_field("status", HANDLE_FW'(exp_r.status), HANDLE_FW'(status));
      end
    end
  end

  function automatic logic [SLOT_FW-1:0] pick_slot();
    logic [SLOT_FW-1:0] live [$];
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i]) live.push_back(i[SLOT_FW-1:0]);
    end
    if (live.size() == 0 || $urandom_range(4) == 0) begin
      return SLOT_FW'($urandom_range(CAPACITY - 1));
    end
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic logic [HANDLE_FW-1:0] pick_handle();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SLOT_FW-1:0] rand_slot();
    return SLOT_FW'($urandom_range(15));
  endfunction

  function automatic logic [SIG_FW-1:0] rand_sig();
    return SIG_FW'($urandom_range(15));
  endfunction

  task automatic test_edge_cases();
    for (int a = int'(ACT_UNBLOCK) + 1; a <= int'(ACT_UNKNOWN_HI); a++) begin
      send_cmd(a[ACT_FW-1:0], '1, SLOT_FW'($urandom_range(CAPACITY - 1)), rand_sig());
    end
    send_cmd(ACT_LOOKUP, '0, '0, '0);
    send_cmd(ACT_REMOVE, '0, '1, '0);
    send_cmd(ACT_BLOCK, '0, '0, '0);
    send_cmd(ACT_INSERT, '0, '1, '1);
    send_cmd(ACT_INSERT, '1, '0, '0);
    send_cmd(ACT_BLOCK, '0, '0, '1);
    send_cmd(ACT_BLOCK, '0, '0, '0);
    send_cmd(ACT_LOOKUP, '0, 4'd0, '0);
    send_cmd(ACT_LOOKUP, '0, 4'd1, '0);
    send_cmd(ACT_UNBLOCK, '0, '0, '1);
    send_cmd(ACT_LOOKUP, '0, 4'd1, '0);
    send_cmd(ACT_REMOVE, '0, 4'd0, '0);
    send_cmd(ACT_LOOKUP, '0, 4'd0, '0);
    send_cmd(ACT_INSERT, 32'h5a5a_a5a5, '0, '0);
    send_cmd(ACT_LOOKUP, '0, 4'd0, '0);
    send_cmd(ACT_UNBLOCK, '0, '0, '0);
    send_cmd(ACT_LOOKUP, '0, 4'd1, '0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i]) send_cmd(ACT_REMOVE, '0, i[SLOT_FW-1:0], '0);
    end
    for (int i = 0; i < CAPACITY; i++) send_cmd(ACT_INSERT, pick_handle(), '0, '0);
    send_cmd(ACT_INSERT, '1, '1, '0);
    send_cmd(ACT_BLOCK, '0, '0, 4'd7);
    send_cmd(ACT_REMOVE, '0, 4'd7, '0);
    send_cmd(ACT_REMOVE, '0, 4'd3, '0);
    send_cmd(ACT_INSERT, 32'h1234_5678, '0, '0);
    send_cmd(ACT_LOOKUP, '0, 4'd3, '0);
    send_cmd(ACT_LOOKUP, '0, 4'd15, '0);
    send_cmd(ACT_REMOVE, '0, '1, '0);
    send_cmd(ACT_LOOKUP, '0, '1, '0);
    send_cmd(ACT_INSERT, '0, '0, '0);
    send_cmd(ACT_INSERT, '0, '0, '0);
  endtask

  task automatic test_random_mix(input int count);
    int insert_pct;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      if ($urandom_range(99) < insert_pct) begin
        send_cmd(ACT_INSERT, pick_handle(), rand_slot(), rand_sig());
      end else begin
        pick = $urandom_range(99);
        if (pick < 35)
          send_cmd(ACT_REMOVE, $urandom(), pick_slot(), rand_sig());
        else if (pick < 70)
          send_cmd(ACT_LOOKUP, $urandom(), pick_slot(), rand_sig());
        else if (pick < 82)
          send_cmd(ACT_BLOCK, $urandom(), rand_slot(), rand_sig());
        else if (pick < 94)
          send_cmd(ACT_UNBLOCK, $urandom(), rand_slot(), rand_sig());
        else
          send_cmd(ACT_FW'($urandom_range(int'(ACT_UNBLOCK) + 1, int'(ACT_UNKNOWN_HI))),
                   $urandom(), rand_slot(), rand_sig());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 21;
    test_edge_cases();
    test_full_table();
    test_random_mix(280);
    sender_idle_pct = 47;
    test_random_mix(280);
    sender_idle_pct = 0;
    test_random_mix(280);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/lfst_pkg.sv
sv/lfst_ram.sv
sv/lfst_ctrl.sv
sv/lfst_dp.sv
sv/lowest_free_slot_table.sv
sv/lfst_checker.sv
verif/testbench.sv
